// File: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cpba_pkg.sv
// Types and constants for the contiguous page bitmap allocator.
// No dependencies; used by the interfaces and the top level.
package cpba_pkg;

    localparam int PAGE_W    = 42;   // width of page numbers and page counts
    localparam int WORD_BITS = 64;
    localparam int KIB_SHIFT = 10;

    localparam logic [13:0] CNT_MAX = 14'h3FFF;
    localparam logic [15:0] KIB_MAX = 16'hFFFF;

    typedef logic [PAGE_W-1:0] page_t;

    typedef logic [1:0] req_type_t;
    localparam req_type_t REQ_ALLOC = 2'd0;
    localparam req_type_t REQ_FREE  = 2'd1;
    localparam req_type_t REQ_STATS = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_EMPTY  = 2'd1;
    localparam status_t STATUS_NO_FIT = 2'd2;
    localparam status_t STATUS_RANGE  = 2'd3;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ARENA_BASE     = 2'd0;
    localparam cfg_index_t CFG_ARENA_BYTES    = 2'd1;
    localparam cfg_index_t CFG_VIRTUAL_OFFSET = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_TEST,
        ST_FETCH,
        ST_ADVANCE,
        ST_MARK,
        ST_CLEAR,
        ST_FREE_UPD,
        ST_PHYS,
        ST_VIRT,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/cpba_if.sv
// Valid/ready channel interfaces for requests, responses and configuration writes.
// Depends on cpba_pkg for field types.
interface cpba_req_if;
    logic                  valid;
    logic                  ready;
    cpba_pkg::req_type_t   req_type;
    logic [31:0]           byte_count;
    logic [31:0]           alignment_bytes;
    logic [63:0]           free_address;

    modport source(output valid, req_type, byte_count, alignment_bytes, free_address,
                   input ready);
    modport sink(input valid, req_type, byte_count, alignment_bytes, free_address,
                 output ready);
endinterface

interface cpba_rsp_if;
    logic                  valid;
    logic                  ready;
    cpba_pkg::status_t     status;
    logic [63:0]           phys_address;
    logic [63:0]           virt_address;
    logic [13:0]           pages_total;
    logic [13:0]           pages_used;
    logic [13:0]           pages_free;
    logic [13:0]           live_allocations;
    logic [15:0]           largest_alloc_kib;

    modport source(output valid, status, phys_address, virt_address, pages_total,
                   pages_used, pages_free, live_allocations, largest_alloc_kib,
                   input ready);
    modport sink(input valid, status, phys_address, virt_address, pages_total,
                 pages_used, pages_free, live_allocations, largest_alloc_kib,
                 output ready);
endinterface

interface cpba_cfg_if;
    logic                   valid;
    logic                   ready;
    cpba_pkg::cfg_index_t   index;
    logic [63:0]            data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/contiguous_page_bitmap_allocator_unit.sv
// Contiguous page bitmap allocator: first-fit aligned page runs over a bitmap memory.
// Depends on cpba_pkg, cpba_if.sv and assert_macros.svh.
// Statistics go straight to the result; a free clears each page of its run, and an allocate tests
// pages, advances candidates and then marks the run, with a word fetch on each bitmap word miss.
// Throughput: one request at a time; the per-page walk over the bitmap memory port sets it.
// Reset clears counters, control state and the per-word valid bits at once; no clearing pass.
`include "assert_macros.svh"

module contiguous_page_bitmap_allocator_unit #(
    parameter int BITMAP_WORDS = 128,
    parameter int PAGE_BYTES   = 4096   // power of two
) (
    input  logic         clk,
    input  logic         rst_n,
    cpba_cfg_if.sink     cfg,
    cpba_req_if.sink     req,
    cpba_rsp_if.source   rsp
);

    localparam int IDX_W    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CAP      = BITMAP_WORDS * cpba_pkg::WORD_BITS;
    localparam int TW       = $clog2(CAP + 1);
    localparam int PAGE_LOG = $clog2(PAGE_BYTES);

    // Configuration registers.
    logic [63:0] arena_base_reg;
    logic [40:0] arena_bytes_reg;
    logic [63:0] virtual_offset_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_base_reg     <= '0;
            arena_bytes_reg    <= '0;
            virtual_offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cpba_pkg::CFG_ARENA_BASE:     arena_base_reg     <= cfg.data;
                cpba_pkg::CFG_ARENA_BYTES:    arena_bytes_reg    <= cfg.data[40:0];
                cpba_pkg::CFG_VIRTUAL_OFFSET: virtual_offset_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Managed page count.
    logic [40:0]       pages_raw;
    logic [TW-1:0]     total;
    cpba_pkg::page_t   total_pg;

    assign pages_raw = arena_bytes_reg >> PAGE_LOG;
    assign total     = (pages_raw > 41'(CAP)) ? TW'(CAP) : TW'(pages_raw);
    assign total_pg  = cpba_pkg::page_t'(total);

    // Control and datapath registers.
    cpba_pkg::state_t    state_reg, state_next;
    cpba_pkg::state_t    ret_reg, ret_next;
    cpba_pkg::req_type_t rtype_reg, rtype_next;
    logic [31:0]         bytes_reg, bytes_next;
    logic [31:0]         align_reg, align_next;
    logic [63:0]         faddr_reg, faddr_next;
    cpba_pkg::page_t     need_reg, need_next;
    cpba_pkg::page_t     step_reg, step_next;
    cpba_pkg::page_t     cand_reg, cand_next;
    cpba_pkg::page_t     p_reg, p_next;
    cpba_pkg::page_t     end_reg, end_next;
    cpba_pkg::status_t   status_reg, status_next;
    logic [63:0]         phys_reg, phys_next;
    logic [63:0]         virt_reg, virt_next;
    logic [13:0]         used_reg, used_next;
    logic [13:0]         acnt_reg, acnt_next;
    logic [15:0]         largest_reg, largest_next;
    logic [63:0]         cache_word_reg, cache_word_next;
    logic [IDX_W-1:0]    cache_idx_reg, cache_idx_next;
    logic                cache_vld_reg, cache_vld_next;

    logic                out_vld_reg, out_vld_next;
    cpba_pkg::status_t   out_status_reg, out_status_next;
    logic [63:0]         out_phys_reg, out_phys_next;
    logic [63:0]         out_virt_reg, out_virt_next;
    logic [13:0]         out_total_reg, out_total_next;
    logic [13:0]         out_used_reg, out_used_next;
    logic [13:0]         out_free_reg, out_free_next;
    logic [13:0]         out_acnt_reg, out_acnt_next;
    logic [15:0]         out_kib_reg, out_kib_next;

    // Bitmap memory with one valid bit per word; an unwritten word reads as all free.
    logic [63:0]              bitmap_mem [BITMAP_WORDS];
    logic [BITMAP_WORDS-1:0]  row_vld_reg;
    logic [63:0]              rd_data_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;
    logic [63:0]              mem_wdata;

    assign rd_addr = p_reg[IDX_W+5:6];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[cache_idx_reg] <= mem_wdata;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
        rd_vld_reg  <= row_vld_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (mem_we)
        begin
            row_vld_reg[cache_idx_reg] <= 1'b1;
        end
    end

    // Request decode helpers.
    logic [32:0]      need_sum;
    cpba_pkg::page_t  step_raw;
    logic [63:0]      addr_off;
    cpba_pkg::page_t  free_start;
    cpba_pkg::page_t  free_end_sum;
    cpba_pkg::page_t  limit;
    logic             miss;
    logic             page_bit;
    logic [63:0]      page_mask;
    logic [63:0]      kib_wide;
    cpba_pkg::page_t  used_sum;
    cpba_pkg::page_t  used_ext;

    assign need_sum     = {1'b0, bytes_reg} + 33'(PAGE_BYTES - 1);
    assign step_raw     = cpba_pkg::page_t'(align_reg >> PAGE_LOG);
    assign addr_off     = faddr_reg - arena_base_reg;
    assign free_start   = cpba_pkg::page_t'(addr_off >> PAGE_LOG);
    assign free_end_sum = free_start + need_reg;
    assign limit        = cand_reg + need_reg;
    assign miss         = !cache_vld_reg || (cache_idx_reg != rd_addr);
    assign page_bit     = cache_word_reg[p_reg[5:0]];
    assign page_mask    = 64'd1 << p_reg[5:0];
    assign kib_wide     = (64'(need_reg) << PAGE_LOG) >> cpba_pkg::KIB_SHIFT;
    assign used_ext     = cpba_pkg::page_t'(used_reg);
    assign used_sum     = used_ext + need_reg;

    assign req.ready = (state_reg == cpba_pkg::ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        rtype_next      = rtype_reg;
        bytes_next      = bytes_reg;
        align_next      = align_reg;
        faddr_next      = faddr_reg;
        need_next       = need_reg;
        step_next       = step_reg;
        cand_next       = cand_reg;
        p_next          = p_reg;
        end_next        = end_reg;
        status_next     = status_reg;
        phys_next       = phys_reg;
        virt_next       = virt_reg;
        used_next       = used_reg;
        acnt_next       = acnt_reg;
        largest_next    = largest_reg;
        cache_word_next = cache_word_reg;
        cache_idx_next  = cache_idx_reg;
        cache_vld_next  = cache_vld_reg;
        mem_we          = 1'b0;
        mem_wdata       = cache_word_reg;

        out_vld_next    = out_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_phys_next   = out_phys_reg;
        out_virt_next   = out_virt_reg;
        out_total_next  = out_total_reg;
        out_used_next   = out_used_reg;
        out_free_next   = out_free_reg;
        out_acnt_next   = out_acnt_reg;
        out_kib_next    = out_kib_reg;

        unique case (state_reg)
            cpba_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    rtype_next = req.req_type;
                    bytes_next = req.byte_count;
                    align_next = req.alignment_bytes;
                    faddr_next = req.free_address;
                    state_next = cpba_pkg::ST_SETUP;
                end
            end

            cpba_pkg::ST_SETUP:
            begin
                need_next   = cpba_pkg::page_t'(need_sum >> PAGE_LOG);
                step_next   = (step_raw == '0) ? cpba_pkg::page_t'(1) : step_raw;
                phys_next   = '0;
                virt_next   = '0;
                status_next = cpba_pkg::STATUS_OK;
                cand_next   = '0;
                p_next      = '0;
                state_next  = cpba_pkg::ST_DONE;
                case (rtype_reg)
                    cpba_pkg::REQ_ALLOC:
                    begin
                        if (bytes_reg == '0 || total == '0)
                        begin
                            status_next = cpba_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            state_next = cpba_pkg::ST_TEST;
                        end
                    end
                    cpba_pkg::REQ_FREE:
                    begin
                        if (bytes_reg == '0 || total == '0)
                        begin
                            status_next = cpba_pkg::STATUS_EMPTY;
                        end
                        else if (faddr_reg < arena_base_reg
                                 || addr_off >= {23'd0, arena_bytes_reg})
                        begin
                            status_next = cpba_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            // need_reg is loaded this cycle; the end page is set next cycle.
                            p_next     = free_start;
                            state_next = cpba_pkg::ST_FREE_UPD;
                            ret_next   = cpba_pkg::ST_SETUP;
                        end
                    end
                    default: ;
                endcase
            end

            cpba_pkg::ST_TEST:
            begin
                if (limit > total_pg)
                begin
                    status_next = cpba_pkg::STATUS_NO_FIT;
                    state_next  = cpba_pkg::ST_DONE;
                end
                else if (miss)
                begin
                    ret_next   = cpba_pkg::ST_TEST;
                    state_next = cpba_pkg::ST_FETCH;
                end
                else if (page_bit)
                begin
                    state_next = cpba_pkg::ST_ADVANCE;
                end
                else if (p_reg + cpba_pkg::page_t'(1) == limit)
                begin
                    p_next     = cand_reg;
                    state_next = cpba_pkg::ST_MARK;
                end
                else
                begin
                    p_next = p_reg + cpba_pkg::page_t'(1);
                end
            end

            cpba_pkg::ST_FETCH:
            begin
                cache_word_next = rd_vld_reg ? rd_data_reg : '0;
                cache_idx_next  = rd_addr;
                cache_vld_next  = 1'b1;
                state_next      = ret_reg;
            end

            cpba_pkg::ST_ADVANCE:
            begin
                // Step to the first aligned candidate past the occupied page.
                if (cand_reg > p_reg)
                begin
                    p_next     = cand_reg;
                    state_next = cpba_pkg::ST_TEST;
                end
                else
                begin
                    cand_next = cand_reg + step_reg;
                end
            end

            cpba_pkg::ST_MARK:
            begin
                if (p_reg == limit)
                begin
                    state_next = cpba_pkg::ST_PHYS;
                end
                else if (miss)
                begin
                    ret_next   = cpba_pkg::ST_MARK;
                    state_next = cpba_pkg::ST_FETCH;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = cache_word_reg | page_mask;
                    cache_word_next = mem_wdata;
                    p_next          = p_reg + cpba_pkg::page_t'(1);
                end
            end

            cpba_pkg::ST_CLEAR:
            begin
                // A run that starts at or past the managed count clears nothing.
                if (p_reg >= end_reg)
                begin
                    used_next  = (used_ext >= need_reg) ? 14'(used_ext - need_reg) : '0;
                    acnt_next  = (acnt_reg != '0) ? acnt_reg - 14'd1 : '0;
                    state_next = cpba_pkg::ST_DONE;
                end
                else if (miss)
                begin
                    ret_next   = cpba_pkg::ST_CLEAR;
                    state_next = cpba_pkg::ST_FETCH;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = cache_word_reg & ~page_mask;
                    cache_word_next = mem_wdata;
                    p_next          = p_reg + cpba_pkg::page_t'(1);
                end
            end

            cpba_pkg::ST_FREE_UPD:
            begin
                // Pages beyond the managed count are skipped.
                end_next   = (free_end_sum > total_pg) ? total_pg : free_end_sum;
                state_next = cpba_pkg::ST_CLEAR;
            end

            cpba_pkg::ST_PHYS:
            begin
                used_next = (used_sum > cpba_pkg::page_t'(cpba_pkg::CNT_MAX))
                          ? cpba_pkg::CNT_MAX : 14'(used_sum);
                acnt_next = (acnt_reg < cpba_pkg::CNT_MAX) ? acnt_reg + 14'd1 : acnt_reg;
                if (kib_wide > 64'(cpba_pkg::KIB_MAX))
                begin
                    largest_next = cpba_pkg::KIB_MAX;
                end
                else if (16'(kib_wide) > largest_reg)
                begin
                    largest_next = 16'(kib_wide);
                end
                phys_next  = arena_base_reg + (64'(cand_reg) << PAGE_LOG);
                state_next = cpba_pkg::ST_VIRT;
            end

            cpba_pkg::ST_VIRT:
            begin
                virt_next  = phys_reg + virtual_offset_reg;
                state_next = cpba_pkg::ST_DONE;
            end

            cpba_pkg::ST_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = status_reg;
                    out_phys_next   = phys_reg;
                    out_virt_next   = virt_reg;
                    out_total_next  = 14'(total);
                    out_used_next   = used_reg;
                    out_free_next   = (total_pg >= used_ext) ? 14'(total_pg - used_ext) : '0;
                    out_acnt_next   = acnt_reg;
                    out_kib_next    = largest_reg;
                    state_next      = cpba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cpba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpba_pkg::ST_IDLE;
            ret_reg       <= cpba_pkg::ST_IDLE;
            used_reg      <= '0;
            acnt_reg      <= '0;
            largest_reg   <= '0;
            cache_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            used_reg      <= used_next;
            acnt_reg      <= acnt_next;
            largest_reg   <= largest_next;
            cache_vld_reg <= cache_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rtype_reg      <= rtype_next;
        bytes_reg      <= bytes_next;
        align_reg      <= align_next;
        faddr_reg      <= faddr_next;
        need_reg       <= need_next;
        step_reg       <= step_next;
        cand_reg       <= cand_next;
        p_reg          <= p_next;
        end_reg        <= end_next;
        status_reg     <= status_next;
        phys_reg       <= phys_next;
        virt_reg       <= virt_next;
        cache_word_reg <= cache_word_next;
        cache_idx_reg  <= cache_idx_next;
        out_status_reg <= out_status_next;
        out_phys_reg   <= out_phys_next;
        out_virt_reg   <= out_virt_next;
        out_total_reg  <= out_total_next;
        out_used_reg   <= out_used_next;
        out_free_reg   <= out_free_next;
        out_acnt_reg   <= out_acnt_next;
        out_kib_reg    <= out_kib_next;
    end

    assign rsp.valid             = out_vld_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.phys_address      = out_phys_reg;
    assign rsp.virt_address      = out_virt_reg;
    assign rsp.pages_total       = out_total_reg;
    assign rsp.pages_used        = out_used_reg;
    assign rsp.pages_free        = out_free_reg;
    assign rsp.live_allocations  = out_acnt_reg;
    assign rsp.largest_alloc_kib = out_kib_reg;

    // A write to the bitmap always goes through a valid cached word.
    `CPBA_ASSERT_IMPL(a_write_cached, mem_we, cache_vld_reg && !miss, "bitmap write without cached word")
    // An accepted request leaves the idle state.
    `CPBA_ASSERT_NEXT(a_req_busy, req.valid && req.ready, state_reg == cpba_pkg::ST_SETUP, "request not started")
    // Only a successful allocation reports nonzero addresses.
    `CPBA_ASSERT_IMPL(a_addr_zero, out_vld_reg && out_status_reg != cpba_pkg::STATUS_OK, out_phys_reg == '0 && out_virt_reg == '0, "address on failed result")

endmodule
